[rtl/core/mse_pkg.sv]
package mse_pkg;

  // Element width; the payload structs below are fixed at this width.
  localparam int DATA_WIDTH = 32;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last;
  } item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         last_out;
    logic                         overflow;
  } result_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PRIME,
    ST_MERGE,
    ST_EMIT_PRIME,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // a request is taken this cycle
    logic merge;      // one merge step: write one element to the destination
    logic emit_rd;    // read addresses follow the emit pointer
    logic emit_take;  // the output register loads the next sorted element
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic single;     // the set closed by this request holds one element
    logic pass_end;   // this merge step writes the final element of a pass
    logic sort_done;  // the pass now ending is the final one
    logic emit_last;  // the element being emitted is the final one
    logic out_free;   // the output register can take a new result
  } status_t;

endpackage

[rtl/core/merge_sort_engine_core.sv]
// Channel  Direction  Handshake                   Payload
// item     in         item_valid / item_stall     mse_pkg::item_t (value, last)
// result   out        result_valid / result_stall mse_pkg::result_t (sorted_value,
//                                                 last_out, overflow)
//
// A request is taken while item_stall is low; one without last gives no result.
// For a set of n elements the sort takes ceil(log2 n) merge passes, each pass
// streaming one element per cycle through the two-bank memory, and the emit
// phase then hands out the sorted elements in order, held off by result_stall.
// Reset is synchronous and active high; it empties the store and the output register.
// While sorting and emitting, item_stall is held high; the output register lets a
// final result wait under result_stall while the next set is already loading.
module merge_sort_engine_core #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  mse_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output mse_pkg::result_t result
);

  // The controller sequences loading, the merge passes and emission; the
  // datapath holds the pointers, the element count and both memory banks.
  mse_pkg::cmd_t    cmd;
  mse_pkg::status_t status;

  mse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .last      (item.last),
    .status    (status),
    .item_stall(item_stall),
    .cmd       (cmd)
  );

  mse_dpath #(
    .DEPTH(DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

[rtl/core/mse_ram.sv]
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[rtl/core/mse_ctrl.sv]
module mse_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             last,
  input  mse_pkg::status_t status,
  output logic             item_stall,
  output mse_pkg::cmd_t    cmd
);

  mse_pkg::state_t state;
  mse_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mse_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mse_pkg::ST_LOAD: begin
        if (item_valid && last) begin
          state_next = status.single ? mse_pkg::ST_EMIT_PRIME : mse_pkg::ST_PRIME;
        end
      end
      mse_pkg::ST_PRIME: begin
        state_next = mse_pkg::ST_MERGE;
      end
      mse_pkg::ST_MERGE: begin
        if (status.pass_end) begin
          state_next = status.sort_done ? mse_pkg::ST_EMIT_PRIME : mse_pkg::ST_PRIME;
        end
      end
      mse_pkg::ST_EMIT_PRIME: begin
        state_next = mse_pkg::ST_EMIT;
      end
      mse_pkg::ST_EMIT: begin
        if (status.out_free && status.emit_last) begin
          state_next = mse_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = mse_pkg::ST_LOAD;
      end
    endcase
  end

  always_comb begin
    item_stall    = 1'b1;
    cmd.load      = 1'b0;
    cmd.merge     = 1'b0;
    cmd.emit_rd   = 1'b0;
    cmd.emit_take = 1'b0;
    unique case (state)
      mse_pkg::ST_LOAD: begin
        item_stall = 1'b0;
        cmd.load   = item_valid;
      end
      mse_pkg::ST_PRIME: begin
      end
      mse_pkg::ST_MERGE: begin
        cmd.merge = 1'b1;
      end
      mse_pkg::ST_EMIT_PRIME: begin
        cmd.emit_rd = 1'b1;
      end
      mse_pkg::ST_EMIT: begin
        cmd.emit_rd   = 1'b1;
        cmd.emit_take = status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/mse_dpath.sv]
module mse_dpath #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  mse_pkg::cmd_t    cmd,
  output mse_pkg::status_t status,
  input  mse_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output mse_pkg::result_t result
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = AW + 3;
  localparam int DW = mse_pkg::DATA_WIDTH;

  // Smallest of a run boundary and the set size.
  function automatic logic [CW-1:0] clip(input logic [PW-1:0] x, input logic [CW-1:0] n);
    logic [CW-1:0] r;
    if (x > PW'(n)) begin
      r = n;
    end else begin
      r = x[CW-1:0];
    end
    return r;
  endfunction

  logic [CW-1:0] count, count_next;
  logic          dropped, dropped_next;
  logic          sel, sel_next;
  logic [PW-1:0] width, width_next;
  logic [CW-1:0] a, a_next;
  logic [CW-1:0] b, b_next;
  logic [CW-1:0] mid, mid_next;
  logic [CW-1:0] hi, hi_next;
  logic [CW-1:0] w, w_next;
  logic [CW-1:0] e, e_next;
  logic          result_valid_next;
  mse_pkg::result_t result_next;

  logic                 full;
  logic [CW-1:0]        n_new;
  logic [CW-1:0]        w_inc;
  logic [CW-1:0]        e_inc;
  logic [PW-1:0]        width2;
  logic [PW-1:0]        width4;
  logic signed [DW-1:0] da, db, wr_val;
  logic                 take_b;
  logic                 seg_end;
  logic                 out_free;

  logic          we0, we1;
  logic [AW-1:0] waddr0;
  logic [DW-1:0] wdata0;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [DW-1:0] rd0_a, rd0_b, rd1_a, rd1_b;

  assign full   = (count == CW'(DEPTH));
  assign n_new  = full ? count : count + CW'(1);
  assign w_inc  = w + CW'(1);
  assign e_inc  = e + CW'(1);
  assign width2 = {width[PW-2:0], 1'b0};
  assign width4 = {width[PW-3:0], 2'b00};

  // The source bank is selected by sel; the other bank receives the merge.
  assign da = sel ? $signed(rd1_a) : $signed(rd0_a);
  assign db = sel ? $signed(rd1_b) : $signed(rd0_b);

  // While both runs hold elements, the right run wins only when it is strictly smaller, which keeps the sort stable.
  assign take_b  = (b < hi) && (!(a < mid) || (da > db));
  assign wr_val  = take_b ? db : da;
  assign seg_end = (w_inc == hi);
  assign out_free = !result_valid || !result_stall;

  assign status.single    = (n_new == CW'(1));
  assign status.pass_end  = cmd.merge && (w_inc == count);
  assign status.sort_done = (width2 >= PW'(count));
  assign status.emit_last = (e_inc == count);
  assign status.out_free  = out_free;

  always_comb begin
    count_next        = count;
    dropped_next      = dropped;
    sel_next          = sel;
    width_next        = width;
    a_next            = a;
    b_next            = b;
    mid_next          = mid;
    hi_next           = hi;
    w_next            = w;
    e_next            = e;
    result_valid_next = result_valid;
    result_next       = result;

    if (cmd.load) begin
      if (full) begin
        dropped_next = 1'b1;
      end else begin
        count_next = n_new;
      end
      if (item.last) begin
        sel_next   = 1'b0;
        width_next = PW'(1);
        a_next     = '0;
        w_next     = '0;
        e_next     = '0;
        mid_next   = clip(PW'(1), n_new);
        b_next     = clip(PW'(1), n_new);
        hi_next    = clip(PW'(2), n_new);
      end
    end

    if (cmd.merge) begin
      w_next = w_inc;
      if (take_b) begin
        b_next = b + CW'(1);
      end else begin
        a_next = a + CW'(1);
      end
      if (seg_end) begin
        if (status.pass_end) begin
          // Next pass runs over runs of twice the width, from the start.
          width_next = width2;
          sel_next   = ~sel;
          a_next     = '0;
          w_next     = '0;
          mid_next   = clip(width2, count);
          b_next     = clip(width2, count);
          hi_next    = clip(width4, count);
        end else begin
          a_next   = hi;
          mid_next = clip(PW'(hi) + width, count);
          b_next   = clip(PW'(hi) + width, count);
          hi_next  = clip(PW'(hi) + width2, count);
        end
      end
    end

    if (cmd.emit_take) begin
      result_valid_next        = 1'b1;
      result_next.sorted_value = da;
      result_next.last_out     = status.emit_last;
      result_next.overflow     = dropped;
      e_next                   = e_inc;
      if (status.emit_last) begin
        count_next   = '0;
        dropped_next = 1'b0;
      end
    end else if (result_valid && !result_stall) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      dropped      <= 1'b0;
      sel          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      count        <= count_next;
      dropped      <= dropped_next;
      sel          <= sel_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    width  <= width_next;
    a      <= a_next;
    b      <= b_next;
    mid    <= mid_next;
    hi     <= hi_next;
    w      <= w_next;
    e      <= e_next;
    result <= result_next;
  end

  // Read addresses follow the next pointer values, so the registered read
  // data always matches the current pointers.
  assign raddr_a = cmd.emit_rd ? e_next[AW-1:0] : a_next[AW-1:0];
  assign raddr_b = b_next[AW-1:0];

  assign we0    = (cmd.load && !full) || (cmd.merge && sel);
  assign waddr0 = cmd.load ? count[AW-1:0] : w[AW-1:0];
  assign wdata0 = cmd.load ? item.value : wr_val;
  assign we1    = cmd.merge && !sel;

  mse_ram #(
    .WIDTH(DW),
    .DEPTH(DEPTH)
  ) u_bank0 (
    .clk    (clk),
    .we     (we0),
    .waddr  (waddr0),
    .wdata  (wdata0),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rd0_a),
    .rdata_b(rd0_b)
  );

  mse_ram #(
    .WIDTH(DW),
    .DEPTH(DEPTH)
  ) u_bank1 (
    .clk    (clk),
    .we     (we1),
    .waddr  (w[AW-1:0]),
    .wdata  (wr_val),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rd1_a),
    .rdata_b(rd1_b)
  );

endmodule

[rtl/core/mse_checker.sv]
module mse_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input mse_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_stall,
  input mse_pkg::result_t result
);

  // A stalled result stays offered and unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // Closing a set raises item_stall, so no further request is taken straight after it.
  a_closed_set_stalls: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.last |=> item_stall)
    else $error("request taken right after the final element of a set");

  // A set closed with the output empty gives no result at once.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.last && !result_valid |=> !result_valid)
    else $error("result appeared too early after a set was closed");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind merge_sort_engine_core mse_checker u_mse_checker (.*);

[tb/tb_merge_sort_engine_core.sv]
`timescale 1ns / 100ps

module tb_merge_sort_engine_core;

  // The store depth matches the default of the block. The figures below set the
  // length of the random part, the length of a hold-off and the limit of the watchdog.
  localparam int DEPTH        = 64;
  localparam int RANDOM_ITEMS = 6;
  localparam int HOLD_CYCLES  = 600;
  localparam int CYCLE_LIMIT  = 300000;

  localparam logic signed [mse_pkg::DATA_WIDTH-1:0] MAX_VAL = 32'sh7fffffff;
  localparam logic signed [mse_pkg::DATA_WIDTH-1:0] MIN_VAL = 32'sh80000000;

  // Every input of the block has a known value from time zero.
  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             item_valid   = 1'b0;
  mse_pkg::item_t   item         = '0;
  logic             result_stall = 1'b0;
  logic             item_stall;
  logic             result_valid;
  mse_pkg::result_t result;

  // Elements of the set that is still being loaded, and whether any of them
  // fell off the end of a full store.
  logic signed [mse_pkg::DATA_WIDTH-1:0] loading_set [$];
  logic                                  loading_dropped = 1'b0;

  // Sorted results that have been predicted but not yet seen at the output.
  mse_pkg::result_t pending_sorted [$];

  int   mismatches      = 0;
  int   cycle_count     = 0;
  int   requests_sent   = 0;
  bit   sender_idles    = 1'b1;
  bit   receiver_stalls = 1'b1;

  // A hold-off of the result channel is asked for by bumping hold_asked; the
  // stall process alone owns the countdown.
  int   hold_asked      = 0;
  int   hold_granted    = 0;
  int   hold_left       = 0;

  merge_sort_engine_core #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  // A 20 ns clock: 10 ns high, 10 ns low.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The watchdog ends a run that has hung, whatever the cause.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result-side back-pressure. A requested hold-off keeps the stall high for a
  // long, counted stretch; otherwise the stall is raised at random with a chance of
  // 31 in a hundred, unless stalling has been switched off for a stretch.
  always @(posedge clk) begin
    if (hold_asked != hold_granted) begin
      hold_granted = hold_asked;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= receiver_stalls && ($urandom_range(99) < 31);
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // Predictor: each accepted request either joins the set being loaded or is
  // dropped when the store is full. A request marked last closes the set, which
  // is then sorted stably in ascending signed order; equal values keep their
  // arrival order because an element only moves past strictly greater ones.
  task automatic accept_element(input logic signed [mse_pkg::DATA_WIDTH-1:0] v,
                                input logic l);
    logic signed [mse_pkg::DATA_WIDTH-1:0] ordered [$];
    logic signed [mse_pkg::DATA_WIDTH-1:0] key;
    mse_pkg::result_t                      r;
    int                                    j;
    if (loading_set.size() < DEPTH) loading_set.push_back(v);
    else loading_dropped = 1'b1;
    if (!l) return;
    ordered = loading_set;
    for (int i = 1; i < ordered.size(); i++) begin
      key = ordered[i];
      j   = i - 1;
      while (j >= 0 && ordered[j] > key) begin
        ordered[j + 1] = ordered[j];
        j--;
      end
      ordered[j + 1] = key;
    end
    for (int i = 0; i < ordered.size(); i++) begin
      r.sorted_value = ordered[i];
      r.last_out     = (i == ordered.size() - 1);
      r.overflow     = loading_dropped;
      pending_sorted.push_back(r);
    end
    loading_set.delete();
    loading_dropped = 1'b0;
  endtask

  // Each result taken from the block is held against the oldest prediction.
  task automatic check_sorted(input mse_pkg::result_t got);
    mse_pkg::result_t want;
    if (pending_sorted.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing predicted",
                                got.sorted_value));
      return;
    end
    want = pending_sorted.pop_front();
    if (got.sorted_value !== want.sorted_value)
      report_mismatch($sformatf("sorted_value %0d, predicted %0d",
                                got.sorted_value, want.sorted_value));
    if (got.last_out !== want.last_out)
      report_mismatch($sformatf("last_out %b, predicted %b on value %0d",
                                got.last_out, want.last_out, want.sorted_value));
    if (got.overflow !== want.overflow)
      report_mismatch($sformatf("overflow %b, predicted %b on value %0d",
                                got.overflow, want.overflow, want.sorted_value));
  endtask

  // Both channels are sampled at the rising edge, so the values seen are the
  // ones that were stable during the cycle that ends there.
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) accept_element(item.value, item.last);
    if (!rst && result_valid && !result_stall) check_sorted(result);
  end

  // Offers one request and returns at the edge at which it is accepted. Any
  // idle cycles are spent before the request is raised, never while it waits,
  // so a stalled request keeps its payload.
  task automatic send_request(input logic signed [mse_pkg::DATA_WIDTH-1:0] v,
                              input logic l);
    mse_pkg::item_t next_req;
    if (sender_idles) begin
      while ($urandom_range(99) < 31) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    next_req.value = v;
    next_req.last  = l;
    item_valid <= 1'b1;
    item       <= next_req;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    requests_sent++;
  endtask

  // Random values lean towards small numbers, so that ties are common, and
  // towards the two extremes; the rest cover the whole 32-bit range.
  function automatic logic signed [mse_pkg::DATA_WIDTH-1:0] random_element();
    logic signed [mse_pkg::DATA_WIDTH-1:0] v;
    v = $urandom;
    case ($urandom_range(3))
      0: v = $urandom_range(8) - 4;
      1: v = $urandom_range(1) ? MAX_VAL : MIN_VAL;
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_random_set(input int n);
    for (int i = 0; i < n; i++) send_request(random_element(), i == n - 1);
  endtask

  // The sender withdraws its request first, so that nothing already accepted is
  // offered again, and the edge just passed has been sampled before the queue
  // of predictions is looked at.
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_sorted.size() != 0) @(posedge clk);
  endtask

  // Sets of one element: nothing to merge, the value comes straight back.
  task automatic test_single_element();
    send_request(MIN_VAL, 1'b1);
    send_request(MAX_VAL, 1'b1);
  endtask

  // The extremes of the signed range, with zero and its neighbours between.
  task automatic test_extreme_values();
    logic signed [mse_pkg::DATA_WIDTH-1:0] vals [7] = '{MAX_VAL, MIN_VAL, 0, -1, 1,
                                                       MIN_VAL + 1, MAX_VAL - 1};
    foreach (vals[i]) send_request(vals[i], i == 6);
  endtask

  // A mostly descending set with repeated values, a pair out of order, and a
  // set that is already sorted.
  task automatic test_order_and_ties();
    logic signed [mse_pkg::DATA_WIDTH-1:0] reversed [8] = '{5, 5, 3, -2, -2, -7, 3,
                                                           MIN_VAL};
    logic signed [mse_pkg::DATA_WIDTH-1:0] ascending [4] = '{-3, -1, 2, 9};
    foreach (reversed[i]) send_request(reversed[i], i == 7);
    send_request(1, 1'b0);
    send_request(0, 1'b1);
    foreach (ascending[i]) send_request(ascending[i], i == 3);
  endtask

  // A set one longer than the store, so that the store fills exactly and the
  // request marked last is itself dropped, then a short set to show that the
  // overflow mark has been cleared.
  task automatic test_store_full();
    send_random_set(DEPTH + 1);
    send_random_set(2);
  endtask

  // The result channel is held off for a long stretch while two sets are
  // offered, so the block stops emitting and stalls its input.
  task automatic test_result_hold_off();
    wait_drained();
    hold_asked++;
    send_random_set(5);
    send_random_set(3);
  endtask

  // A stretch with no idling on either side: requests and results move at the
  // full rate that the block allows.
  task automatic test_back_to_back();
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    for (int s = 0; s < 3; s++) send_random_set($urandom_range(2, 6));
    wait_drained();
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  // Random sets, mostly short, now and then of medium length.
  task automatic test_random_sets();
    int start_count;
    start_count = requests_sent;
    while (requests_sent - start_count < RANDOM_ITEMS) begin
      if ($urandom_range(9) == 0) send_random_set($urandom_range(7, 10));
      else send_random_set($urandom_range(1, 6));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_single_element();
    test_extreme_values();
    test_order_and_ties();
    test_store_full();
    test_result_hold_off();
    test_back_to_back();
    test_random_sets();
    // Every set has been closed, so all predictions are in place; wait for the
    // last of them, then a while longer for any stray result.
    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/mse_pkg.sv
rtl/core/mse_ram.sv
rtl/core/mse_ctrl.sv
rtl/core/mse_dpath.sv
rtl/core/merge_sort_engine_core.sv
rtl/core/mse_checker.sv
tb/tb_merge_sort_engine_core.sv
